// ===== design/assert_macros.svh =====
// assertion macros shared by the planner rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition in one cycle implies a condition in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== design/srdp_pkg.sv =====
// types, codes and constants of the sector read deblock planner
// no dependencies
package srdp_pkg;

	localparam int unsigned SECT_BYTES   = 512;
	localparam int unsigned BLK_BYTES    = 2048;
	localparam int unsigned SECT_PER_BLK = BLK_BYTES / SECT_BYTES;
	localparam int unsigned SPB_BITS     = $clog2(SECT_PER_BLK);
	localparam int unsigned BLK_SHIFT    = $clog2(BLK_BYTES);

	// result slots in emission order
	localparam int unsigned NUM_SLOTS = 3;
	localparam int unsigned SL_HEAD   = 0;
	localparam int unsigned SL_MID    = 1;
	localparam int unsigned SL_TAIL   = 2;

	typedef enum logic [1:0] {
		ST_ISSUED = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FAIL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MD_PASS  = 2'd0,
		MD_FAIL  = 2'd1,
		MD_EMPTY = 2'd2,
		MD_SPLIT = 2'd3
	} mode_t;

	typedef struct packed {
		logic [31:0] start_sector;
		logic [15:0] sector_total;
		logic [15:0] device_block_bytes;
		logic        deblock_enable;
	} req_t;

	typedef struct packed {
		status_t     plan_status;
		logic [31:0] device_address;
		logic [15:0] device_blocks;
		logic [31:0] transfer_bytes;
		logic        via_bounce;
		logic [1:0]  copy_offset;
		logic [15:0] delivered_sectors;
		logic [15:0] dest_offset;
		logic        last_chunk;
	} res_t;

	// decoded request handed from decode to split
	typedef struct packed {
		mode_t       mode;
		logic [31:0] start_sector;
		logic [15:0] sector_total;
		logic [31:0] pass_bytes;
		logic        head_en;
		logic [2:0]  head_chunk;
		logic [31:0] next_sector;
		logic [15:0] rest;
	} dec_t;

	// up to three planned reads, mask bit set for each present slot
	typedef struct packed {
		logic [NUM_SLOTS-1:0]       mask;
		res_t [NUM_SLOTS-1:0]       slot;
	} plan_t;

endpackage

// ===== design/srdp_if.sv =====
// request and planned-read channel interfaces, valid/ready handshake
// no dependencies
interface srdp_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] start_sector;
	logic [15:0] sector_total;
	logic [15:0] device_block_bytes;
	logic        deblock_enable;

	modport source (output valid, start_sector, sector_total, device_block_bytes,
		deblock_enable, input ready);
	modport sink (input valid, start_sector, sector_total, device_block_bytes,
		deblock_enable, output ready);
endinterface

interface srdp_plan_if;
	logic        valid;
	logic        ready;
	logic [1:0]  plan_status;
	logic [31:0] device_address;
	logic [15:0] device_blocks;
	logic [31:0] transfer_bytes;
	logic        via_bounce;
	logic [1:0]  copy_offset;
	logic [15:0] delivered_sectors;
	logic [15:0] dest_offset;
	logic        last_chunk;

	modport source (output valid, plan_status, device_address, device_blocks,
		transfer_bytes, via_bounce, copy_offset, delivered_sectors, dest_offset,
		last_chunk, input ready);
	modport sink (input valid, plan_status, device_address, device_blocks,
		transfer_bytes, via_bounce, copy_offset, delivered_sectors, dest_offset,
		last_chunk, output ready);
endinterface

// ===== design/srdp_decode.sv =====
// stages 1 and 2: input register, mode decode, head chunk and byte product
// depends on srdp_pkg and srdp_req_if
module srdp_decode import srdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	srdp_req_if.sink   req,
	output logic       dn_valid,
	input  logic       dn_ready,
	output dec_t       dn_dec
);

	logic       v_s1, v_s2;
	logic       rdy_s1, rdy_s2;
	req_t       req_s1;
	dec_t       dec_s2;
	dec_t       dec_nxt;
	logic [1:0] off;
	logic [2:0] room;
	logic       blk512, blk2k;

	assign rdy_s2    = !v_s2 || dn_ready;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req.ready = rdy_s1;
	assign dn_valid  = v_s2;
	assign dn_dec    = dec_s2;

	always_comb begin
		off    = req_s1.start_sector[SPB_BITS-1:0];
		room   = 3'(SECT_PER_BLK) - {1'b0, off};
		blk512 = req_s1.device_block_bytes == 16'(SECT_BYTES);
		blk2k  = req_s1.device_block_bytes == 16'(BLK_BYTES);

		dec_nxt              = '0;
		dec_nxt.start_sector = req_s1.start_sector;
		dec_nxt.sector_total = req_s1.sector_total;
		dec_nxt.pass_bytes   = 32'(req_s1.sector_total) * 32'(req_s1.device_block_bytes);
		if (!req_s1.deblock_enable || blk512) begin
			dec_nxt.mode = MD_PASS;
		end else if (!blk2k) begin
			dec_nxt.mode = MD_FAIL;
		end else if (req_s1.sector_total == '0) begin
			dec_nxt.mode = MD_EMPTY;
		end else begin
			dec_nxt.mode = MD_SPLIT;
		end

		// partial head block: misaligned start or less than one block
		if (off != '0) begin
			dec_nxt.head_en    = 1'b1;
			dec_nxt.head_chunk = (req_s1.sector_total < 16'(room)) ?
				req_s1.sector_total[2:0] : room;
		end else if (req_s1.sector_total < 16'(SECT_PER_BLK)) begin
			dec_nxt.head_en    = 1'b1;
			dec_nxt.head_chunk = req_s1.sector_total[2:0];
		end
		dec_nxt.next_sector = req_s1.start_sector + 32'(dec_nxt.head_chunk);
		dec_nxt.rest        = req_s1.sector_total - 16'(dec_nxt.head_chunk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= req.valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && req.valid) begin
			req_s1.start_sector       <= req.start_sector;
			req_s1.sector_total       <= req.sector_total;
			req_s1.device_block_bytes <= req.device_block_bytes;
			req_s1.deblock_enable     <= req.deblock_enable;
		end
		if (rdy_s2 && v_s1) begin
			dec_s2 <= dec_nxt;
		end
	end

endmodule

// ===== design/srdp_split.sv =====
// stage 3: builds head, middle and tail read records from the decoded request
// depends on srdp_pkg
module srdp_split import srdp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  up_valid,
	output logic  up_ready,
	input  dec_t  up_dec,
	output logic  dn_valid,
	input  logic  dn_ready,
	output plan_t dn_plan
);

	logic        v_s3;
	logic        rdy_s3;
	plan_t       plan_s3;
	plan_t       plan_nxt;
	logic [13:0] mid_blocks;
	logic [15:0] mid_chunk;
	logic [1:0]  tail_chunk;
	logic        mid_en, tail_en;
	logic [31:0] tail_sector;

	assign rdy_s3   = !v_s3 || dn_ready;
	assign up_ready = rdy_s3;
	assign dn_valid = v_s3;
	assign dn_plan  = plan_s3;

	always_comb begin
		mid_blocks  = up_dec.rest[15:SPB_BITS];
		mid_chunk   = {up_dec.rest[15:SPB_BITS], {SPB_BITS{1'b0}}};
		tail_chunk  = up_dec.rest[SPB_BITS-1:0];
		mid_en      = mid_blocks != '0;
		tail_en     = tail_chunk != '0;
		tail_sector = up_dec.next_sector + 32'(mid_chunk);

		plan_nxt = '0;
		case (up_dec.mode)
			MD_PASS: begin
				plan_nxt.mask                            = 3'b001;
				plan_nxt.slot[SL_HEAD].plan_status       = ST_ISSUED;
				plan_nxt.slot[SL_HEAD].device_address    = up_dec.start_sector;
				plan_nxt.slot[SL_HEAD].device_blocks     = up_dec.sector_total;
				plan_nxt.slot[SL_HEAD].transfer_bytes    = up_dec.pass_bytes;
				plan_nxt.slot[SL_HEAD].delivered_sectors = up_dec.sector_total;
				plan_nxt.slot[SL_HEAD].last_chunk        = 1'b1;
			end
			MD_FAIL: begin
				plan_nxt.mask                      = 3'b001;
				plan_nxt.slot[SL_HEAD].plan_status = ST_FAIL;
				plan_nxt.slot[SL_HEAD].last_chunk  = 1'b1;
			end
			MD_EMPTY: begin
				plan_nxt.mask                      = 3'b001;
				plan_nxt.slot[SL_HEAD].plan_status = ST_EMPTY;
				plan_nxt.slot[SL_HEAD].last_chunk  = 1'b1;
			end
			MD_SPLIT: begin
				plan_nxt.mask = {tail_en, mid_en, up_dec.head_en};

				plan_nxt.slot[SL_HEAD].plan_status       = ST_ISSUED;
				plan_nxt.slot[SL_HEAD].device_address    = up_dec.start_sector >> SPB_BITS;
				plan_nxt.slot[SL_HEAD].device_blocks     = 16'd1;
				plan_nxt.slot[SL_HEAD].transfer_bytes    = 32'(BLK_BYTES);
				plan_nxt.slot[SL_HEAD].via_bounce        = 1'b1;
				plan_nxt.slot[SL_HEAD].copy_offset       = up_dec.start_sector[SPB_BITS-1:0];
				plan_nxt.slot[SL_HEAD].delivered_sectors = 16'(up_dec.head_chunk);
				plan_nxt.slot[SL_HEAD].last_chunk        = !mid_en && !tail_en;

				plan_nxt.slot[SL_MID].plan_status       = ST_ISSUED;
				plan_nxt.slot[SL_MID].device_address    = up_dec.next_sector >> SPB_BITS;
				plan_nxt.slot[SL_MID].device_blocks     = 16'(mid_blocks);
				plan_nxt.slot[SL_MID].transfer_bytes    = 32'(mid_blocks) << BLK_SHIFT;
				plan_nxt.slot[SL_MID].delivered_sectors = mid_chunk;
				plan_nxt.slot[SL_MID].dest_offset       = 16'(up_dec.head_chunk);
				plan_nxt.slot[SL_MID].last_chunk        = !tail_en;

				plan_nxt.slot[SL_TAIL].plan_status       = ST_ISSUED;
				plan_nxt.slot[SL_TAIL].device_address    = tail_sector >> SPB_BITS;
				plan_nxt.slot[SL_TAIL].device_blocks     = 16'd1;
				plan_nxt.slot[SL_TAIL].transfer_bytes    = 32'(BLK_BYTES);
				plan_nxt.slot[SL_TAIL].via_bounce        = 1'b1;
				plan_nxt.slot[SL_TAIL].delivered_sectors = 16'(tail_chunk);
				plan_nxt.slot[SL_TAIL].dest_offset       = 16'(up_dec.head_chunk) + mid_chunk;
				plan_nxt.slot[SL_TAIL].last_chunk        = 1'b1;
			end
			default: begin
				plan_nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && up_valid) begin
			plan_s3 <= plan_nxt;
		end
	end

endmodule

// ===== design/srdp_emit.sv =====
// serializer: holds one plan and, while the sink is ready, sends its reads one per
// cycle through an output register; depends on srdp_pkg and srdp_plan_if
module srdp_emit import srdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	output logic        up_ready,
	input  plan_t       up_plan,
	srdp_plan_if.source plan
);

	logic [NUM_SLOTS-1:0] mask_q;
	res_t [NUM_SLOTS-1:0] slot_q;
	logic                 out_valid_q;
	res_t                 out_q;
	logic                 load_ok;
	logic                 one_left;
	logic [NUM_SLOTS-1:0] pick;
	res_t                 rec;

	assign load_ok  = !out_valid_q || plan.ready;
	assign one_left = (mask_q & (mask_q - 3'd1)) == '0;
	assign up_ready = (mask_q == '0) || (load_ok && one_left);
	// lowest pending slot goes out first
	assign pick     = mask_q & (~mask_q + 3'd1);

	always_comb begin
		rec = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (pick[i]) begin
				rec = slot_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (up_valid && up_ready) begin
				mask_q <= up_plan.mask;
			end else if (load_ok) begin
				mask_q <= mask_q & ~pick;
			end
			if (load_ok) begin
				out_valid_q <= mask_q != '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			slot_q <= up_plan.slot;
		end
		if (load_ok && (mask_q != '0)) begin
			out_q <= rec;
		end
	end

	assign plan.valid             = out_valid_q;
	assign plan.plan_status       = out_q.plan_status;
	assign plan.device_address    = out_q.device_address;
	assign plan.device_blocks     = out_q.device_blocks;
	assign plan.transfer_bytes    = out_q.transfer_bytes;
	assign plan.via_bounce        = out_q.via_bounce;
	assign plan.copy_offset       = out_q.copy_offset;
	assign plan.delivered_sectors = out_q.delivered_sectors;
	assign plan.dest_offset       = out_q.dest_offset;
	assign plan.last_chunk        = out_q.last_chunk;

endmodule

// ===== design/sector_read_deblock_planner.sv =====
// a request passes the input, decode and split registers, then the serializer plan and output registers
// each request has 1 to 3 planned reads; while the sink is ready, the single
// output register of the serializer sends one read per cycle
// reset: arst_n clears all valid bits and the pending-read mask, payload is kept
// depends on srdp_pkg, srdp_if, srdp_decode, srdp_split, srdp_emit, assert_macros.svh
`include "assert_macros.svh"

module sector_read_deblock_planner import srdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	srdp_req_if.sink    req,
	srdp_plan_if.source plan
);

	// decode to split
	logic  dc_valid;
	logic  dc_ready;
	dec_t  dc_dec;

	// split to serializer
	logic  sp_valid;
	logic  sp_ready;
	plan_t sp_plan;

	// stages 1-2: register the request, classify it (pass-through, failure,
	// empty, split), size the head chunk and form the pass-through byte count
	srdp_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.dn_valid (dc_valid),
		.dn_ready (dc_ready),
		.dn_dec   (dc_dec)
	);

	// stage 3: lay out head (bounce), middle (direct whole blocks) and
	// tail (bounce) reads with addresses, destinations and last flags
	srdp_split u_split (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (dc_valid),
		.up_ready (dc_ready),
		.up_dec   (dc_dec),
		.dn_valid (sp_valid),
		.dn_ready (sp_ready),
		.dn_plan  (sp_plan)
	);

	// serializer: takes the next plan in the same cycle its last read leaves,
	// so the pipeline only stalls while a request still has reads pending
	srdp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sp_valid),
		.up_ready (sp_ready),
		.up_plan  (sp_plan),
		.plan     (plan)
	);

	// every plan leaving split holds at least one read
	`ASSERT_ALWAYS(a_plan_nonempty, clk, arst_n, !sp_valid || (sp_plan.mask != '0), "empty plan")
	// status results stand alone and carry no read
	`ASSERT_ALWAYS(a_status_alone, clk, arst_n, !plan.valid || (plan.plan_status == ST_ISSUED) || (plan.last_chunk && (plan.device_blocks == '0)), "bad status item")
	// bounce reads are one device block and copy within it
	`ASSERT_ALWAYS(a_bounce_fit, clk, arst_n, !plan.valid || !plan.via_bounce || ((plan.device_blocks == 16'd1) && ((17'(plan.copy_offset) + 17'(plan.delivered_sectors)) <= 17'(SECT_PER_BLK))), "bounce read out of block")
	// the reads of one request follow without a gap
	`ASSERT_NEXT(a_chunks_contiguous, clk, arst_n, plan.valid && plan.ready && !plan.last_chunk, plan.valid, "gap inside a request")

endmodule
